### src/fctc_pkg.sv
`timescale 1ns / 1ps

package fctc_pkg;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_SWAP_ONE = 2'd0,
        REG_SWAP_TWO = 2'd1,
        REG_BLINK    = 2'd2
    } t_reg_idx;

    localparam logic [7:0]  CMD_IDLE     = 8'h00;
    localparam logic [7:0]  CMD_IDENT    = 8'h01;
    localparam logic [7:0]  CMD_LOAD     = 8'h0C;
    localparam logic [7:0]  CMD_COUNTS   = 8'h10;
    localparam logic [7:0]  PAD_BYTE     = 8'hFF;
    localparam logic [15:0] BLINK_RESET  = 16'd500;
    localparam logic [3:0]  IDENT_LAST   = 4'd6;
    localparam logic [3:0]  COUNTS_LAST  = 4'd15;

    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h6F;
            3'd1:    b = 8'h64;
            3'd2:    b = 8'h73;
            3'd3:    b = 8'h70;
            3'd4:    b = 8'h30;
            3'd5:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### src/four_channel_toggle_counter_regs_top.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)               tuser       tlast
// s_axis    in         pin_levels[3:0], data_byte[11:4]  kind[1:0]   end_of_write
// m_axis    out        read_byte[7:0], led_level[8]      read_valid  last_of_run
// cfg       in         wdata[15:0] at index idx          -           -
//
// Samples, written bytes and ticks: one item per cycle while s_tready is high, one result each.
// Read request: a single 0x00 answer, or a run of 7 ID bytes or 16 count bytes,
// set by the byte sequencer feeding the output register.
// Reset is synchronous, active low; clears all state but output byte/flags, loads register defaults.
// s_tready drops while the output register is full and not taken, or a run is out.

module four_channel_toggle_counter_regs_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // pin_levels[3:0], data_byte[11:4], zero[15:12]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    input  logic        i_s_tlast,

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // read_byte[7:0], led_level[8], zero[15:9]
    output logic        o_m_tuser,   // read_valid
    output logic        o_m_tlast,

    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic        r_swap1, r_swap2;
    logic [15:0] r_blink;

    logic [7:0]  r_pending, n_pending;
    logic [1:0]  r_load_cnt, n_load_cnt;
    logic [31:0] r_load_val, n_load_val;
    logic        r_discard, n_discard;
    logic [3:0]  r_levels, n_levels;
    logic [31:0] r_count [4];
    logic [31:0] n_count [4];
    logic [31:0] r_seen [4];
    logic [31:0] n_seen [4];
    logic [31:0] r_time, n_time;
    logic [31:0] r_check, n_check;
    logic        r_led, n_led;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_rvalid;
    logic        r_out_last;
    logic        r_out_led;

    logic        r_run_active, n_run_active;
    logic        r_run_ident, n_run_ident;
    logic [3:0]  r_run_idx, n_run_idx;

    logic        out_free;
    logic        in_acc;
    fctc_pkg::t_kind kind;
    logic [3:0]  levels;
    logic [7:0]  wbyte;

    logic [31:0] shifted;
    logic [31:0] load_word;
    logic        do_load;
    logic [31:0] time_inc;
    logic [31:0] elapsed;
    logic        changed;

    logic [1:0]  run_ch;
    logic [31:0] run_word;
    logic [31:0] run_shifted;
    logic [4:0]  run_sh;
    logic [7:0]  run_byte;
    logic        run_last;

    logic        emit_now;
    logic [7:0]  emit_byte;
    logic        emit_rvalid;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = out_free && !r_run_active;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign kind       = fctc_pkg::t_kind'(i_s_tuser);
    assign levels     = i_s_tdata[3:0];
    assign wbyte      = i_s_tdata[11:4];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_led, r_out_byte};
    assign o_m_tuser  = r_out_rvalid;
    assign o_m_tlast  = r_out_last;

    // read-out byte from live counts or the ID table; nothing else is accepted during a run
    assign run_ch      = {r_run_idx[3], r_run_idx[2] ^ (r_run_idx[3] ? r_swap2 : r_swap1)};
    assign run_word    = r_count[run_ch];
    assign run_sh      = {~r_run_idx[1:0], 3'b000};
    assign run_shifted = run_word >> run_sh;
    assign run_byte    = r_run_ident ? fctc_pkg::ident_byte(r_run_idx[2:0])
                                     : run_shifted[7:0];
    assign run_last    = r_run_ident ? (r_run_idx == fctc_pkg::IDENT_LAST)
                                     : (r_run_idx == fctc_pkg::COUNTS_LAST);

    assign shifted  = {r_load_val[23:0], wbyte};
    assign time_inc = r_time + 32'd1;
    assign elapsed  = time_inc - r_check;
    assign changed  = (r_count[0] != r_seen[0]) || (r_count[1] != r_seen[1]) ||
                      (r_count[2] != r_seen[2]) || (r_count[3] != r_seen[3]);

    always_comb begin
        n_pending    = r_pending;
        n_load_cnt   = r_load_cnt;
        n_load_val   = r_load_val;
        n_discard    = r_discard;
        n_levels     = r_levels;
        n_count      = r_count;
        n_seen       = r_seen;
        n_time       = r_time;
        n_check      = r_check;
        n_led        = r_led;
        n_run_active = r_run_active;
        n_run_ident  = r_run_ident;
        n_run_idx    = r_run_idx;
        load_word    = shifted;
        do_load      = 1'b0;
        emit_now     = 1'b0;
        emit_byte    = 8'h00;
        emit_rvalid  = 1'b0;

        if (r_run_active && out_free) begin
            n_run_idx = r_run_idx + 4'd1;
            if (run_last) begin
                n_run_active = 1'b0;
            end
        end

        if (in_acc) begin
            emit_now = 1'b1;
            unique case (kind)
                fctc_pkg::KIND_SAMPLE: begin
                    for (int i = 0; i < 4; i++) begin
                        if (levels[i] != r_levels[i]) begin
                            n_levels[i] = levels[i];
                            n_count[i]  = r_count[i] + 32'd1;
                        end
                    end
                end
                fctc_pkg::KIND_WRITE: begin
                    if (r_discard) begin
                        if (i_s_tlast) begin
                            n_discard = 1'b0;
                        end
                    end else if (r_pending == fctc_pkg::CMD_IDLE) begin
                        n_pending  = wbyte;
                        n_load_cnt = 2'd0;
                        n_load_val = 32'd0;
                    end else if (r_pending == fctc_pkg::CMD_LOAD) begin
                        if (r_load_cnt == 2'd3) begin
                            do_load    = 1'b1;
                            n_pending  = fctc_pkg::CMD_IDLE;
                            n_load_cnt = 2'd0;
                            n_load_val = 32'd0;
                            n_discard  = !i_s_tlast;
                        end else if (i_s_tlast) begin
                            unique case (r_load_cnt)
                                2'd0:    load_word = {wbyte, {3{fctc_pkg::PAD_BYTE}}};
                                2'd1:    load_word = {shifted[15:0], {2{fctc_pkg::PAD_BYTE}}};
                                default: load_word = {shifted[23:0], fctc_pkg::PAD_BYTE};
                            endcase
                            do_load    = 1'b1;
                            n_pending  = fctc_pkg::CMD_IDLE;
                            n_load_cnt = 2'd0;
                            n_load_val = 32'd0;
                        end else begin
                            n_load_val = shifted;
                            n_load_cnt = r_load_cnt + 2'd1;
                        end
                    end else begin
                        n_pending  = fctc_pkg::CMD_IDLE;
                        n_load_cnt = 2'd0;
                        n_load_val = 32'd0;
                        n_discard  = !i_s_tlast;
                    end
                end
                fctc_pkg::KIND_READ: begin
                    n_pending  = fctc_pkg::CMD_IDLE;
                    n_load_cnt = 2'd0;
                    n_load_val = 32'd0;
                    n_discard  = 1'b0;
                    if (r_pending == fctc_pkg::CMD_IDENT ||
                        r_pending == fctc_pkg::CMD_COUNTS) begin
                        emit_now     = 1'b0;
                        n_run_active = 1'b1;
                        n_run_ident  = (r_pending == fctc_pkg::CMD_IDENT);
                        n_run_idx    = 4'd0;
                    end else begin
                        emit_rvalid = 1'b1;
                    end
                end
                fctc_pkg::KIND_TICK: begin
                    n_time = time_inc;
                    if (elapsed > {16'd0, r_blink}) begin
                        n_check = time_inc;
                        if (changed) begin
                            n_seen = r_count;
                            n_led  = !r_led;
                        end
                    end
                end
            endcase
            if (do_load) begin
                for (int i = 0; i < 4; i++) begin
                    n_count[i] = load_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap1      <= 1'b0;
            r_swap2      <= 1'b0;
            r_blink      <= fctc_pkg::BLINK_RESET;
            r_pending    <= fctc_pkg::CMD_IDLE;
            r_load_cnt   <= 2'd0;
            r_load_val   <= 32'd0;
            r_discard    <= 1'b0;
            r_levels     <= 4'd0;
            r_time       <= 32'd0;
            r_check      <= 32'd0;
            r_led        <= 1'b0;
            r_run_active <= 1'b0;
            r_run_ident  <= 1'b0;
            r_run_idx    <= 4'd0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_count[i] <= 32'd0;
                r_seen[i]  <= 32'd0;
            end
        end else begin
            if (i_cfg_wen) begin
                unique case (fctc_pkg::t_reg_idx'(i_cfg_idx))
                    fctc_pkg::REG_SWAP_ONE: r_swap1 <= i_cfg_wdata[0];
                    fctc_pkg::REG_SWAP_TWO: r_swap2 <= i_cfg_wdata[0];
                    fctc_pkg::REG_BLINK:    r_blink <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_pending    <= n_pending;
            r_load_cnt   <= n_load_cnt;
            r_load_val   <= n_load_val;
            r_discard    <= n_discard;
            r_levels     <= n_levels;
            r_count      <= n_count;
            r_seen       <= n_seen;
            r_time       <= n_time;
            r_check      <= n_check;
            r_led        <= n_led;
            r_run_active <= n_run_active;
            r_run_ident  <= n_run_ident;
            r_run_idx    <= n_run_idx;
            if (out_free) begin
                r_out_valid <= emit_now || r_run_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run_active && out_free) begin
            r_out_byte   <= run_byte;
            r_out_rvalid <= 1'b1;
            r_out_last   <= run_last;
            r_out_led    <= r_led;
        end else if (emit_now) begin
            r_out_byte   <= emit_byte;
            r_out_rvalid <= emit_rvalid;
            r_out_last   <= 1'b1;
            r_out_led    <= n_led;
        end
    end

    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_active |-> !o_s_tready)
        else $error("item accepted during read run");

    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && o_m_tdata[7:0] == 8'h00))
        else $error("non-read result not a single zero item");

    a_led_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_led != $past(r_led)) |->
            $past(in_acc && i_s_tuser == fctc_pkg::KIND_TICK))
        else $error("led changed without tick");

    a_ident_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_active && r_run_ident) |-> (r_run_idx <= fctc_pkg::IDENT_LAST))
        else $error("ident run index out of range");

endmodule
